// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define CPCB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define CPCB_NEVER(label, clk, rst, expr, msg) \
   `CPCB_ASSERT(label, clk, rst, !(expr), msg)

`endif

// ----- rtl/cpcb_pkg.sv -----
package cpcb_pkg;

   localparam int CPCB_MAX_SYMBOLS     = 288;
   localparam int CPCB_MAX_CODE_LENGTH = 15;

   localparam int SYM_W  = 9;
   localparam int LEN_W  = 4;
   localparam int CODE_W = 16;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [SYM_W-1:0]  symbol;
      logic [LEN_W-1:0]  length;
      logic              last;
   } cpcb_req_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  code_length;
   } cpcb_rsp_type;

   // One symbol RAM entry: stored length and assigned code.
   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } cpcb_entry_type;

   // Builder status toward the top level.
   typedef struct packed {
      logic active;
      logic wr_en;
   } cpcb_bld_ctl_type;

   // A length takes part in the code only when it is nonzero and within range.
   function automatic logic cpcb_len_ok(input logic [LEN_W-1:0] len,
                                        input logic [LEN_W-1:0] max_len);
      return (len != '0) && (len <= max_len);
   endfunction

endpackage

// ----- rtl/cpcb_ram.sv -----
module cpcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/cpcb_build.sv -----
`include "assert_macros.svh"

module cpcb_build #(
   parameter int MAX_SYMBOLS     = cpcb_pkg::CPCB_MAX_SYMBOLS,
   parameter int MAX_CODE_LENGTH = cpcb_pkg::CPCB_MAX_CODE_LENGTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 go,
   input  logic [$clog2(MAX_SYMBOLS+1)-1:0]     count,
   input  cpcb_pkg::cpcb_entry_type             rd_entry,
   output cpcb_pkg::cpcb_bld_ctl_type           ctl,
   output logic [$clog2(MAX_SYMBOLS)-1:0]       rd_addr,
   output logic [$clog2(MAX_SYMBOLS)-1:0]       wr_addr,
   output cpcb_pkg::cpcb_entry_type             wr_entry
);

   import cpcb_pkg::*;

   localparam int CNT_W   = $clog2(MAX_SYMBOLS + 1);
   localparam int ADDR_W  = $clog2(MAX_SYMBOLS);
   localparam int LIDX_W  = $clog2(MAX_CODE_LENGTH + 1);
   localparam int NUM_LEN = MAX_CODE_LENGTH + 1;

   typedef enum logic [3:0] {
      B_IDLE   = 4'b0001,
      B_TALLY  = 4'b0010,
      B_FIRST  = 4'b0100,
      B_ASSIGN = 4'b1000
   } cpcb_bld_state_type;

   cpcb_bld_state_type state_ff, state_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [LIDX_W-1:0]  num_ff, num_in;
   logic [CODE_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]   tally_ff [NUM_LEN];
   logic [CNT_W-1:0]   tally_in [NUM_LEN];
   logic [CODE_W-1:0]  next_ff [NUM_LEN];
   logic [CODE_W-1:0]  next_in [NUM_LEN];

   logic               issue;
   logic               len_hit;
   logic [LIDX_W-1:0]  len_idx;
   logic [CODE_W-1:0]  acc_sum;
   logic [CODE_W-1:0]  acc_next;
   logic               wr_en;

   assign issue   = ((state_ff == B_TALLY) || (state_ff == B_ASSIGN)) && (idx_ff < count);
   assign len_hit = pend_ff && cpcb_len_ok(rd_entry.len, LEN_W'(MAX_CODE_LENGTH));
   assign len_idx = rd_entry.len[LIDX_W-1:0];

   // First code of the next length: previous first code plus count, doubled.
   assign acc_sum  = acc_ff + CODE_W'(tally_ff[LIDX_W'(num_ff - 1'b1)]);
   assign acc_next = {acc_sum[CODE_W-2:0], 1'b0};

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_addr_in = idx_ff[ADDR_W-1:0];
      num_in       = num_ff;
      acc_in       = acc_ff;
      tally_in     = tally_ff;
      next_in      = next_ff;
      wr_en        = 1'b0;
      wr_entry     = '{len: rd_entry.len, code: '0};
      case (state_ff)
         B_IDLE: begin
            if (go) begin
               state_in = B_TALLY;
               idx_in   = '0;
               tally_in = '{default: '0};
            end
         end
         B_TALLY: begin
            pend_in = issue;
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (len_hit) begin
               tally_in[len_idx] = tally_ff[len_idx] + 1'b1;
            end
            if (!issue) begin
               state_in = B_FIRST;
               num_in   = LIDX_W'(1);
               acc_in   = '0;
            end
         end
         B_FIRST: begin
            next_in[num_ff] = acc_next;
            acc_in          = acc_next;
            num_in          = num_ff + 1'b1;
            if (num_ff == LIDX_W'(MAX_CODE_LENGTH)) begin
               state_in = B_ASSIGN;
               idx_in   = '0;
            end
         end
         B_ASSIGN: begin
            pend_in = issue;
            if (issue) begin
               idx_in = idx_ff + 1'b1;
            end
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if (len_hit) begin
               wr_entry.code     = next_ff[len_idx];
               next_in[len_idx] = next_ff[len_idx] + 1'b1;
            end
            if (!issue) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      num_ff       <= num_in;
      acc_ff       <= acc_in;
      tally_ff     <= tally_in;
      next_ff      <= next_in;
   end

   assign ctl.active = (state_ff != B_IDLE);
   assign ctl.wr_en  = wr_en;
   assign rd_addr    = idx_ff[ADDR_W-1:0];
   assign wr_addr    = pend_addr_ff;

   `CPCB_ASSERT(a_first_no_write, clock, reset, (state_ff == B_FIRST) |-> !wr_en, "write in first-code phase")
   `CPCB_ASSERT(a_idx_bound, clock, reset, ((state_ff == B_TALLY) || (state_ff == B_ASSIGN)) |-> (idx_ff <= count), "scan index past count")
   `CPCB_ASSERT(a_write_after_read, clock, reset, wr_en |-> $past(issue), "write without a prior read")

endmodule

// ----- rtl/canonical_prefix_code_builder_top.sv -----
// Read word: result on rsp_strobe the cycle after the read is taken; one read per cycle while not busy.
// Length write: one per cycle while not busy. A write marked last holds busy through the build:
//   one symbol RAM pass to count lengths, one step per length, one pass to assign.
// Results leave on a one-cycle strobe with no holding; the receiver cannot stall them.
// Reset: synchronous, active high; clears control state, the load count and the table-valid flag.
//   The symbol RAM is not cleared: entries beyond the load count are masked on read.
`include "assert_macros.svh"

module canonical_prefix_code_builder_top #(
   parameter int MAX_SYMBOLS     = cpcb_pkg::CPCB_MAX_SYMBOLS,
   parameter int MAX_CODE_LENGTH = cpcb_pkg::CPCB_MAX_CODE_LENGTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  cpcb_pkg::cpcb_req_type req_word,
   output logic                   busy,
   output logic                   rsp_strobe,
   output cpcb_pkg::cpcb_rsp_type rsp_word
);

   import cpcb_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
   localparam int ADDR_W = $clog2(MAX_SYMBOLS);
   localparam int CMP_W  = (CNT_W > SYM_W) ? CNT_W : SYM_W;

   // Load and read-path state.
   logic [CNT_W-1:0] loaded_ff, loaded_in;
   logic             table_valid_ff, table_valid_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic             hit_ff, hit_in;
   logic             code_ok_ff, code_ok_in;

   logic             accept;
   logic             wr_acc;
   logic             rd_acc;
   logic [CNT_W-1:0] base;
   logic             load_we;
   logic             go;

   cpcb_bld_ctl_type      bld_ctl;
   logic [ADDR_W-1:0]     bld_raddr;
   logic [ADDR_W-1:0]     bld_waddr;
   cpcb_entry_type        bld_wentry;

   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic [ADDR_W-1:0]     ram_raddr;
   cpcb_entry_type        ram_wentry;
   logic [$bits(cpcb_entry_type)-1:0] ram_rdata;
   cpcb_entry_type        rd_entry;

   // Take a word only while no build runs.
   assign accept = start && !busy;
   assign wr_acc = accept && (req_word.kind == KIND_WRITE);
   assign rd_acc = accept && (req_word.kind == KIND_READ);

   // A write after a built table restarts loading at symbol zero.
   assign base    = table_valid_ff ? '0 : loaded_ff;
   // Drop lengths once the table is full.
   assign load_we = wr_acc && (base < CNT_W'(MAX_SYMBOLS));
   // The last mark starts the build, even on a dropped write.
   assign go      = wr_acc && req_word.last;

   always_comb begin
      loaded_in      = loaded_ff;
      table_valid_in = table_valid_ff;
      if (wr_acc) begin
         loaded_in      = load_we ? (base + 1'b1) : base;
         table_valid_in = req_word.last;
      end
      // Snapshot the read qualifiers; the RAM data arrives in the next cycle.
      rsp_strobe_in = rd_acc;
      hit_in        = CMP_W'(req_word.symbol) < CMP_W'(loaded_ff);
      code_ok_in    = hit_in && table_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff      <= '0;
         table_valid_ff <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         loaded_ff      <= loaded_in;
         table_valid_ff <= table_valid_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
      hit_ff     <= hit_in;
      code_ok_ff <= code_ok_in;
   end

   cpcb_build #(
      .MAX_SYMBOLS     (MAX_SYMBOLS),
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
   ) u_build (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .count    (loaded_ff),
      .rd_entry (rd_entry),
      .ctl      (bld_ctl),
      .rd_addr  (bld_raddr),
      .wr_addr  (bld_waddr),
      .wr_entry (bld_wentry)
   );

   // Hand the RAM ports to the builder while it runs, else to the load and read words.
   assign ram_we     = load_we || bld_ctl.wr_en;
   assign ram_waddr  = bld_ctl.active ? bld_waddr : base[ADDR_W-1:0];
   assign ram_wentry = bld_ctl.active ? bld_wentry
                                      : cpcb_entry_type'{len: req_word.length, code: '0};
   assign ram_raddr  = bld_ctl.active ? bld_raddr : ADDR_W'(req_word.symbol);

   cpcb_ram #(
      .WIDTH ($bits(cpcb_entry_type)),
      .DEPTH (MAX_SYMBOLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wentry),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_entry = cpcb_entry_type'(ram_rdata);

   // Mask unloaded symbols; show codes only for a built table and an in-range length.
   assign busy                 = bld_ctl.active;
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_word.code_length = hit_ff ? rd_entry.len : '0;
   assign rsp_word.code        = (code_ok_ff && cpcb_len_ok(rd_entry.len, LEN_W'(MAX_CODE_LENGTH)))
                                 ? rd_entry.code : '0;

   `CPCB_ASSERT(a_rsp_after_read, clock, reset, rsp_strobe |-> $past(start && !busy && (req_word.kind == KIND_READ)), "result without a read")
   `CPCB_ASSERT(a_loaded_bound, clock, reset, loaded_ff <= CNT_W'(MAX_SYMBOLS), "load count past table size")
   `CPCB_NEVER(a_no_load_in_build, clock, reset, load_we && bld_ctl.active, "length write during build")

endmodule
